// ===== hw/rtl/krsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krsa_pkg: shared types and constants for the key repeat setpoint adjust
// Field widths, key timing limits, setpoint clamp bounds and register
// indexes used by the key timers, the adjust logic and the top level.
// ----------------------------------------------------------------------------
package krsa_pkg;

    // fixed field widths
    localparam int SETPOINT_W = 10;
    localparam int COUNT_W    = 6;
    localparam int REPEAT_W   = 4;
    localparam int TICKS_W    = 6;
    localparam int KEY_COUNT  = 3;

    // word widths on the stream ports
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_TICKS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS  = 1'd1;

    // configuration reset values
    localparam logic [TICKS_W-1:0] PRESS_TICKS_RST = 6'd2;
    localparam logic [TICKS_W-1:0] HOLD_TICKS_RST  = 6'd20;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // key timing
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = 6'd50;
    localparam logic [REPEAT_W:0]   REPEAT_PERIOD = 5'd10;

    // setpoint step and clamp bounds, on a 12-bit signed intermediate
    localparam int SUM_W = 12;
    localparam logic signed [SUM_W-1:0] STEP_ONE   = 12'sd10;
    localparam logic signed [SUM_W-1:0] STEP_TWO   = 12'sd20;
    localparam logic signed [SUM_W-1:0] UP_CEIL    = 12'sd750;
    localparam logic signed [SUM_W-1:0] LOW_FLOOR  = 12'sd80;
    localparam logic signed [SUM_W-1:0] HIGH_FLOOR = 12'sd100;

    // events of one key on one tick
    typedef struct packed {
        logic press;
        logic repeat_hit;
    } t_key_fire;

endpackage

// ===== hw/rtl/krsa_key_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krsa_key_timer: press counter and repeat divider of one key
// Counts ticks while the key is held, saturating, and flags the single
// press event and the periodic repeat events for the current tick.
// ----------------------------------------------------------------------------
module krsa_key_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_update,     // tick word being applied
    input  logic                          i_level,      // key held
    input  logic [krsa_pkg::TICKS_W-1:0]  i_press_ticks,
    input  logic [krsa_pkg::TICKS_W-1:0]  i_hold_ticks,
    output krsa_pkg::t_key_fire           o_fire
);

    logic [krsa_pkg::COUNT_W-1:0]  r_press_count;
    logic [krsa_pkg::COUNT_W-1:0]  n_press_count;
    logic [krsa_pkg::REPEAT_W-1:0] r_repeat_count;
    logic [krsa_pkg::REPEAT_W-1:0] n_repeat_count;
    logic [krsa_pkg::COUNT_W-1:0]  press_inc;
    logic [krsa_pkg::REPEAT_W:0]   repeat_inc;
    logic                          hold_reached;

    // press counter: count while held, saturate, clear on release
    always_comb begin
        press_inc = r_press_count + krsa_pkg::COUNT_W'(1);
        if (!i_level) begin
            n_press_count = '0;
        end else if (press_inc >= krsa_pkg::COUNT_MAX) begin
            n_press_count = krsa_pkg::COUNT_MAX;
        end else begin
            n_press_count = press_inc;
        end
    end

    // event detection and repeat divider, divider kept across release
    always_comb begin
        o_fire.press = ({1'b0, n_press_count} == ({1'b0, i_press_ticks} + 7'd1));
        hold_reached = ({1'b0, n_press_count} >= ({1'b0, i_hold_ticks} + 7'd1));
        repeat_inc   = {1'b0, r_repeat_count} + 5'd1;
        o_fire.repeat_hit = hold_reached && (repeat_inc >= krsa_pkg::REPEAT_PERIOD);
        if (!hold_reached) begin
            n_repeat_count = r_repeat_count;
        end else if (o_fire.repeat_hit) begin
            n_repeat_count = '0;
        end else begin
            n_repeat_count = repeat_inc[krsa_pkg::REPEAT_W-1:0];
        end
    end

    // counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_count  <= '0;
            r_repeat_count <= '0;
        end else if (i_update) begin
            r_press_count  <= n_press_count;
            r_repeat_count <= n_repeat_count;
        end
    end

endmodule

// ===== hw/rtl/krsa_adjust.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krsa_adjust: clamped setpoint steps for the three keys
// Applies key 1 (up, ceiling), key 2 (down, low floor) and key 3 (down,
// high floor) in order; a key firing twice moves by two steps at once.
// ----------------------------------------------------------------------------
module krsa_adjust (
    input  logic [krsa_pkg::SETPOINT_W-1:0]  i_setpoint,
    input  krsa_pkg::t_key_fire              i_fire [krsa_pkg::KEY_COUNT],
    output logic [krsa_pkg::SETPOINT_W-1:0]  o_setpoint,
    output logic [krsa_pkg::KEY_COUNT-1:0]   o_event_mask
);

    logic signed [krsa_pkg::SUM_W-1:0] step   [krsa_pkg::KEY_COUNT];
    logic                              active [krsa_pkg::KEY_COUNT];
    logic signed [krsa_pkg::SUM_W-1:0] s0;
    logic signed [krsa_pkg::SUM_W-1:0] s1;
    logic signed [krsa_pkg::SUM_W-1:0] s2;
    logic signed [krsa_pkg::SUM_W-1:0] s3;
    logic signed [krsa_pkg::SUM_W-1:0] t0;
    logic signed [krsa_pkg::SUM_W-1:0] t1;
    logic signed [krsa_pkg::SUM_W-1:0] t2;

    // step size per key: one or two events this tick
    always_comb begin
        for (int k = 0; k < krsa_pkg::KEY_COUNT; k++) begin
            active[k] = i_fire[k].press || i_fire[k].repeat_hit;
            step[k]   = (i_fire[k].press && i_fire[k].repeat_hit) ? krsa_pkg::STEP_TWO
                                                                  : krsa_pkg::STEP_ONE;
            o_event_mask[k] = active[k];
        end
    end

    // key 1 up with ceiling, key 2 and key 3 down with floors
    always_comb begin
        s0 = krsa_pkg::SUM_W'(i_setpoint);

        t0 = s0 + step[0];
        if (!active[0])                   s1 = s0;
        else if (t0 >= krsa_pkg::UP_CEIL) s1 = krsa_pkg::UP_CEIL;
        else                              s1 = t0;

        t1 = s1 - step[1];
        if (!active[1])                     s2 = s1;
        else if (t1 <= krsa_pkg::LOW_FLOOR) s2 = krsa_pkg::LOW_FLOOR;
        else                                s2 = t1;

        t2 = s2 - step[2];
        if (!active[2])                      s3 = s2;
        else if (t2 <= krsa_pkg::HIGH_FLOOR) s3 = krsa_pkg::HIGH_FLOOR;
        else                                 s3 = t2;

        o_setpoint = s3[krsa_pkg::SETPOINT_W-1:0];
    end

endmodule

// ===== hw/rtl/key_repeat_setpoint_adjust.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_repeat_setpoint_adjust: debounced keys with auto-repeat on a setpoint
// Each input word is either a tick with three key levels or a setpoint load;
// each gives one output word with the new setpoint and the fired-key mask.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one word per timer tick or load. tuser carries
//   the operation (0 tick, 1 load); tdata carries the key levels and the
//   load value. Output stream (m_axis_*): one word per input word, with the
//   setpoint after that word and a mask of keys that fired on the tick.
//   Config port (cfg): index 0 press_ticks, index 1 hold_ticks; always
//   ready. The user must write it only while no word is in flight; the
//   block does not enforce this. An input register, then key timers and
//   clamp logic feed the output register.
//   Throughput is one word per cycle while the receiver does not stall;
//   the key counter and setpoint update is combinational logic between the
//   registers, so consecutive words follow back to back.
//   When the receiver stalls, the output register holds its word and the
//   input register still takes one more word before tready drops.
//   Reset clears the counters, the setpoint (to zero) and the valid flags of
//   both registers, and sets press_ticks to 2 and hold_ticks to 20.
// ----------------------------------------------------------------------------
module key_repeat_setpoint_adjust #(
    parameter int NUM_KEYS = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] key_up_down, [1] key_down_low, [2] key_down_high, [12:3] load_value
    input  logic [krsa_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] operation
    input  logic [0:0]                           s_axis_tuser,
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [9:0] setpoint, [12:10] event_mask
    output logic [krsa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [krsa_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [krsa_pkg::TICKS_W-1:0]         i_cfg_data
);

    localparam int ACTIVE_KEYS = (NUM_KEYS < krsa_pkg::KEY_COUNT) ? NUM_KEYS
                                                                  : krsa_pkg::KEY_COUNT;

    logic [krsa_pkg::TICKS_W-1:0]    r_press_ticks;
    logic [krsa_pkg::TICKS_W-1:0]    r_hold_ticks;
    logic                            r_in_valid;
    logic                            r_in_op;
    logic [krsa_pkg::KEY_COUNT-1:0]  r_in_levels;
    logic [krsa_pkg::SETPOINT_W-1:0] r_in_load;
    logic [krsa_pkg::SETPOINT_W-1:0] r_setpoint;
    logic [krsa_pkg::SETPOINT_W-1:0] n_setpoint;
    logic                            r_out_valid;
    logic [krsa_pkg::SETPOINT_W-1:0] r_out_setpoint;
    logic [krsa_pkg::KEY_COUNT-1:0]  r_out_mask;
    logic [krsa_pkg::KEY_COUNT-1:0]  n_out_mask;
    logic                            advance;
    logic                            key_update;
    logic [krsa_pkg::SETPOINT_W-1:0] adj_setpoint;
    logic [krsa_pkg::KEY_COUNT-1:0]  adj_mask;
    krsa_pkg::t_key_fire             key_fire [krsa_pkg::KEY_COUNT];

    // handshake
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign key_update    = r_in_valid && advance && (r_in_op == krsa_pkg::OP_TICK);
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ticks <= krsa_pkg::PRESS_TICKS_RST;
            r_hold_ticks  <= krsa_pkg::HOLD_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                krsa_pkg::REG_PRESS_TICKS: r_press_ticks <= i_cfg_data;
                krsa_pkg::REG_HOLD_TICKS:  r_hold_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op     <= s_axis_tuser[0];
            r_in_levels <= s_axis_tdata[krsa_pkg::KEY_COUNT-1:0];
            r_in_load   <= s_axis_tdata[krsa_pkg::KEY_COUNT +: krsa_pkg::SETPOINT_W];
        end
    end

    // key timers for the keys that exist, the rest never fire
    for (genvar k = 0; k < krsa_pkg::KEY_COUNT; k++) begin : g_key
        if (k < ACTIVE_KEYS) begin : g_timer
            krsa_key_timer u_timer (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_update      (key_update),
                .i_level       (r_in_levels[k]),
                .i_press_ticks (r_press_ticks),
                .i_hold_ticks  (r_hold_ticks),
                .o_fire        (key_fire[k])
            );
        end else begin : g_none
            assign key_fire[k] = '0;
        end
    end

    // clamped steps
    krsa_adjust u_adjust (
        .i_setpoint   (r_setpoint),
        .i_fire       (key_fire),
        .o_setpoint   (adj_setpoint),
        .o_event_mask (adj_mask)
    );

    // load replaces the setpoint, tick takes the adjusted value
    always_comb begin
        if (r_in_op == krsa_pkg::OP_LOAD) begin
            n_setpoint = r_in_load;
            n_out_mask = '0;
        end else begin
            n_setpoint = adj_setpoint;
            n_out_mask = adj_mask;
        end
    end

    // setpoint state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
        end else if (r_in_valid && advance) begin
            r_setpoint <= n_setpoint;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out_setpoint <= n_setpoint;
            r_out_mask     <= n_out_mask;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        (krsa_pkg::OUT_DATA_W - krsa_pkg::SETPOINT_W - krsa_pkg::KEY_COUNT)'(0),
        r_out_mask,
        r_out_setpoint
    };

endmodule

// ===== bench/key_repeat_setpoint_adjust_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_repeat_setpoint_adjust_tb: self-checking bench for the setpoint keys
// Drives tick and load words on the input stream, tracks the key counters,
// repeat dividers and the setpoint in a local model, and compares every
// output word with the expected setpoint and fired-key mask. Covers the load
// extremes, the three clamps, double firing, thresholds that never fire,
// random key hold sequences, idle gaps on both sides and a long output stall.
// ----------------------------------------------------------------------------
module key_repeat_setpoint_adjust_tb;

    // key positions in the level field
    localparam int KEY_UP        = 0;
    localparam int KEY_DOWN_LOW  = 1;
    localparam int KEY_DOWN_HIGH = 2;

    typedef struct packed {
        logic [krsa_pkg::SETPOINT_W-1:0] setpoint;
        logic [krsa_pkg::KEY_COUNT-1:0]  event_mask;
    } t_adjust_word;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [krsa_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
    logic [0:0]                        s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [krsa_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [krsa_pkg::CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [krsa_pkg::TICKS_W-1:0]      i_cfg_data = '0;

    // model of the key timers and the setpoint
    logic [krsa_pkg::COUNT_W-1:0]      press_cnt [krsa_pkg::KEY_COUNT];
    logic [krsa_pkg::REPEAT_W-1:0]     rpt_cnt [krsa_pkg::KEY_COUNT];
    logic [krsa_pkg::SETPOINT_W-1:0]   sp_model;
    logic [krsa_pkg::TICKS_W-1:0]      cfg_press;
    logic [krsa_pkg::TICKS_W-1:0]      cfg_hold;

    t_adjust_word            adjust_q [$];
    int                      mismatch_count = 0;
    int                      src_idle_pct = 0;
    int                      snk_idle_pct = 0;
    int                      stall_left = 0;

    key_repeat_setpoint_adjust uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // one step of a key on the setpoint, clamped after the step
    function automatic logic [krsa_pkg::SETPOINT_W-1:0] nudge_setpoint(
        input int key,
        input logic [krsa_pkg::SETPOINT_W-1:0] sp
    );
        int s;
        s = int'(sp);
        case (key)
            KEY_UP: begin
                s = s + int'(krsa_pkg::STEP_ONE);
                if (s >= int'(krsa_pkg::UP_CEIL)) s = int'(krsa_pkg::UP_CEIL);
            end
            KEY_DOWN_LOW: begin
                s = s - int'(krsa_pkg::STEP_ONE);
                if (s <= int'(krsa_pkg::LOW_FLOOR)) s = int'(krsa_pkg::LOW_FLOOR);
            end
            KEY_DOWN_HIGH: begin
                s = s - int'(krsa_pkg::STEP_ONE);
                if (s <= int'(krsa_pkg::HIGH_FLOOR)) s = int'(krsa_pkg::HIGH_FLOOR);
            end
            default: ;
        endcase
        return s[krsa_pkg::SETPOINT_W-1:0];
    endfunction

    // advance the model by one word and return the expected output word
    function automatic t_adjust_word adjust_keys(
        input logic op,
        input logic [krsa_pkg::KEY_COUNT-1:0] keys,
        input logic [krsa_pkg::SETPOINT_W-1:0] load
    );
        t_adjust_word w;
        int k;
        int pc;
        int rc;
        w.event_mask = '0;
        if (op == krsa_pkg::OP_LOAD) begin
            sp_model = load;
        end else begin
            for (k = 0; k < krsa_pkg::KEY_COUNT; k++) begin
                pc = int'(press_cnt[k]);
                if (keys[k]) begin
                    pc++;
                    if (pc >= int'(krsa_pkg::COUNT_MAX)) pc = int'(krsa_pkg::COUNT_MAX);
                end else begin
                    pc = 0;
                end
                press_cnt[k] = pc[krsa_pkg::COUNT_W-1:0];
                // single press event
                if (pc == int'(cfg_press) + 1) begin
                    sp_model = nudge_setpoint(k, sp_model);
                    w.event_mask[k] = 1'b1;
                end
                // auto-repeat divider, kept across releases
                if (pc >= int'(cfg_hold) + 1) begin
                    rc = int'(rpt_cnt[k]) + 1;
                    if (rc >= int'(krsa_pkg::REPEAT_PERIOD)) begin
                        sp_model = nudge_setpoint(k, sp_model);
                        w.event_mask[k] = 1'b1;
                        rc = 0;
                    end
                    rpt_cnt[k] = rc[krsa_pkg::REPEAT_W-1:0];
                end
            end
        end
        w.setpoint = sp_model;
        return w;
    endfunction

    // state after reset
    task automatic clear_model();
        int k;
        for (k = 0; k < krsa_pkg::KEY_COUNT; k++) begin
            press_cnt[k] = '0;
            rpt_cnt[k] = '0;
        end
        sp_model = '0;
        cfg_press = krsa_pkg::PRESS_TICKS_RST;
        cfg_hold = krsa_pkg::HOLD_TICKS_RST;
    endtask

    // offer one input word, with a random idle gap in front
    task automatic send_word(input logic op, input logic [krsa_pkg::KEY_COUNT-1:0] keys,
                             input logic [krsa_pkg::SETPOINT_W-1:0] load);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= krsa_pkg::IN_DATA_W'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b000, load, keys};
        do @(posedge i_clk); while (!s_axis_tready);
        adjust_q.push_back(adjust_keys(op, keys, load));
    endtask

    // hold the input until every expected word has come out
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (adjust_q.size() != 0);
    endtask

    // write both timing registers while the block is idle
    task automatic set_timing(input logic [krsa_pkg::TICKS_W-1:0] press,
                              input logic [krsa_pkg::TICKS_W-1:0] hold);
        wait_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= krsa_pkg::REG_PRESS_TICKS;
        i_cfg_data <= press;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_press = press;
        i_cfg_index <= krsa_pkg::REG_HOLD_TICKS;
        i_cfg_data <= hold;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_hold = hold;
        i_cfg_valid <= 1'b0;
    endtask

    // loads at both ends of the range, key levels ignored on a load
    task automatic test_load_extremes();
        send_word(krsa_pkg::OP_LOAD, 3'b000, 10'd0);
        send_word(krsa_pkg::OP_LOAD, 3'b111, 10'd1023);
    endtask

    // each key crossing its clamp bound, with the reset press threshold
    task automatic test_setpoint_clamps();
        int i;
        send_word(krsa_pkg::OP_LOAD, 3'b000, 10'd745);
        for (i = 0; i < 3; i++)
            send_word(krsa_pkg::OP_TICK, 3'b001, krsa_pkg::SETPOINT_W'($urandom));
        send_word(krsa_pkg::OP_LOAD, 3'b000, 10'd85);
        for (i = 0; i < 3; i++)
            send_word(krsa_pkg::OP_TICK, 3'b010, krsa_pkg::SETPOINT_W'($urandom));
        send_word(krsa_pkg::OP_LOAD, 3'b000, 10'd105);
        for (i = 0; i < 3; i++)
            send_word(krsa_pkg::OP_TICK, 3'b100, krsa_pkg::SETPOINT_W'($urandom));
    endtask

    // press and repeat on the same tick apply the step twice
    task automatic test_double_fire();
        int i;
        int len;
        set_timing(6'd0, 6'd0);
        send_word(krsa_pkg::OP_LOAD, 3'b000, 10'd400);
        // bring the repeat divider of key 1 to nine, then release and press
        len = int'(krsa_pkg::REPEAT_PERIOD) - 1 - int'(rpt_cnt[KEY_UP]);
        for (i = 0; i < len; i++)
            send_word(krsa_pkg::OP_TICK, 3'b001, krsa_pkg::SETPOINT_W'($urandom));
        send_word(krsa_pkg::OP_TICK, 3'b000, krsa_pkg::SETPOINT_W'($urandom));
        send_word(krsa_pkg::OP_TICK, 3'b001, krsa_pkg::SETPOINT_W'($urandom));
    endtask

    // random hold sequences, loads and noise
    task automatic test_random_keys(input int n_items);
        int left;
        int kind;
        int len;
        int i;
        logic [krsa_pkg::KEY_COUNT-1:0] keys;
        logic [krsa_pkg::SETPOINT_W-1:0] load;
        left = n_items;
        while (left > 0) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                // steady hold of one key set, sometimes past saturation
                keys = krsa_pkg::KEY_COUNT'($urandom_range(7, 1));
                len = $urandom_range(1) ? $urandom_range(15, 1) : $urandom_range(70, 16);
                for (i = 0; i < len && left > 0; i++) begin
                    send_word(krsa_pkg::OP_TICK, keys, krsa_pkg::SETPOINT_W'($urandom));
                    left--;
                end
                if ($urandom_range(1) && left > 0) begin
                    send_word(krsa_pkg::OP_TICK, 3'b000, krsa_pkg::SETPOINT_W'($urandom));
                    left--;
                end
            end else if (kind < 82) begin
                // load mostly inside the clamp window
                load = $urandom_range(3) ? krsa_pkg::SETPOINT_W'($urandom_range(780, 60))
                                         : krsa_pkg::SETPOINT_W'($urandom);
                send_word(krsa_pkg::OP_LOAD, krsa_pkg::KEY_COUNT'($urandom), load);
                left--;
            end else begin
                // short burst of random levels
                len = $urandom_range(10, 1);
                for (i = 0; i < len && left > 0; i++) begin
                    send_word($urandom_range(9) == 0 ? krsa_pkg::OP_LOAD : krsa_pkg::OP_TICK,
                              krsa_pkg::KEY_COUNT'($urandom),
                              krsa_pkg::SETPOINT_W'($urandom));
                    left--;
                end
            end
        end
    endtask

    // long output stall while key words keep coming
    task automatic test_backpressure();
        int i;
        wait_results();
        stall_left = 60;
        for (i = 0; i < 30; i++)
            send_word(krsa_pkg::OP_TICK, 3'b011, krsa_pkg::SETPOINT_W'($urandom));
    endtask

    // output side ready, with random stalls and an optional long hold-off
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // compare each output word with the oldest expectation
    always @(posedge i_clk) begin
        t_adjust_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (adjust_q.size() == 0) begin
                $error("unexpected output word: setpoint %0d event_mask %0d",
                       m_axis_tdata[9:0], m_axis_tdata[12:10]);
                mismatch_count++;
            end else begin
                want = adjust_q.pop_front();
                if (m_axis_tdata[9:0] !== want.setpoint) begin
                    $error("setpoint: expected %0d actual %0d", want.setpoint,
                           m_axis_tdata[9:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[12:10] !== want.event_mask) begin
                    $error("event_mask: expected %0d actual %0d", want.event_mask,
                           m_axis_tdata[12:10]);
                    mismatch_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        clear_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        src_idle_pct = 7;
        snk_idle_pct = 82;
        test_load_extremes();
        test_setpoint_clamps();
        test_random_keys(300);
        test_double_fire();
        test_random_keys(200);

        // sender mostly idle, receiver mostly ready
        src_idle_pct = 82;
        snk_idle_pct = 7;
        set_timing(6'd63, 6'd63);
        test_random_keys(100);
        set_timing(6'd49, 6'd49);
        test_random_keys(150);
        set_timing(6'd50, 6'd0);
        test_random_keys(150);

        // no idling on either side
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_timing(krsa_pkg::TICKS_W'($urandom_range(12)),
                   krsa_pkg::TICKS_W'($urandom_range(30)));
        test_random_keys(300);
        test_backpressure();
        set_timing(6'd3, 6'd12);
        test_random_keys(250);

        wait_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/krsa_pkg.sv
hw/rtl/krsa_key_timer.sv
hw/rtl/krsa_adjust.sv
hw/rtl/key_repeat_setpoint_adjust.sv
bench/key_repeat_setpoint_adjust_tb.sv
